@@ design/gbp_pkg.sv @@
package gbp_pkg;

  localparam int FRAC_BITS = 16;

  // Register map of the configuration port.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BULGE_RADIUS = 8'd3;

  localparam logic [31:0] MIN_RESET   = 32'd0;
  localparam logic [31:0] MAX_RESET   = 32'd6553600;
  localparam logic [15:0] COUNT_RESET = 16'd256;
  localparam logic [31:0] BULGE_RESET = 32'd655360;
  localparam logic [31:0] STEP_RESET  = 32'(MAX_RESET / COUNT_RESET);

  localparam int STEP_DIV_BITS = 32;

  // Fourth root as two chained square roots, one result bit per stage.
  localparam int SQ1_STEPS = (64 - FRAC_BITS + 1) / 2;
  localparam int SQ1_IN_W  = 2 * SQ1_STEPS;
  localparam int SQ2_STEPS = (SQ1_STEPS + 32 + 1) / 2;
  localparam int SQ2_IN_W  = 2 * SQ2_STEPS;
  localparam int SQ_REM_W  = SQ2_STEPS + 2;
  localparam int SD_N      = SQ1_STEPS + SQ2_STEPS;

  // Exponents are Q.24; anything at or above 32.0 gives zero brightness.
  localparam int EXP_FRAC = 24;
  localparam int ED_W     = EXP_FRAC + 5;
  localparam int X_W      = ED_W + 1;

  localparam logic [26:0] K_Q32   = 27'd85899346;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [16:0] INT_ONE = 17'h10000;

  localparam int HORNER_TERMS = 12;
  localparam int HORNER_N     = 3 * HORNER_TERMS;
  localparam int SQUARINGS    = 5;
  localparam int EX_N         = 2 + HORNER_N + SQUARINGS;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [31:0] max_radius;
    logic [31:0] bulge_radius;
  } shape_cfg_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ2_STEPS-1:0] root;
  } sq_pair_t;

  typedef struct packed {
    logic [31:0]          radius;
    logic                 disk;
    logic                 sat;
    logic [31:0]          src;
    logic [33:0]          d3;
    logic [SQ_REM_W-1:0]  sq_rem;
    logic [SQ2_STEPS-1:0] sq_root;
    logic [SQ1_STEPS-1:0] s1;
    logic [31:0]          dv_rem;
    logic [ED_W-1:0]      dv_q;
  } sd_stage_t;

  typedef struct packed {
    logic [31:0]     radius;
    logic            zero;
    logic            big;
    logic [X_W-1:0]  x;
    logic [ED_W-1:0] ed;
    logic [31:0]     f;
    logic [32:0]     r;
    logic [31:0]     p;
    logic [31:0]     qa;
  } ex_stage_t;

  // floor(2^32 / k) for the Horner divisors.
  function automatic logic [32:0] recip(input int k);
    logic [32:0] m;
    case (k)
      1:       m = 33'd4294967296;
      2:       m = 33'd2147483648;
      3:       m = 33'd1431655765;
      4:       m = 33'd1073741824;
      5:       m = 33'd858993459;
      6:       m = 33'd715827882;
      7:       m = 33'd613566756;
      8:       m = 33'd536870912;
      9:       m = 33'd477218588;
      10:      m = 33'd429496729;
      11:      m = 33'd390451572;
      default: m = 33'd357913941;
    endcase
    return m;
  endfunction

  // One digit of a restoring integer square root.
  function automatic sq_pair_t sqrt_step(input logic [SQ_REM_W-1:0] rem,
                                         input logic [SQ2_STEPS-1:0] root,
                                         input logic [1:0] bits);
    logic [SQ_REM_W+1:0] cur;
    logic [SQ_REM_W+1:0] trial;
    sq_pair_t res;
    cur   = {rem, bits};
    trial = {2'b00, root, 2'b01};
    if (cur >= trial) begin
      res.rem  = SQ_REM_W'(cur - trial);
      res.root = {root[SQ2_STEPS-2:0], 1'b1};
    end else begin
      res.rem  = SQ_REM_W'(cur);
      res.root = {root[SQ2_STEPS-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

@@ design/galaxy_brightness_profile.sv @@
// Throughput: one item per cycle; the 97-stage evaluator stalls only when the
// four-entry output queue is full.
// After each configuration write, full stays high while the step width divider
// runs. Reset loads the register defaults and empties both queues.
module galaxy_brightness_profile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [15:0]                   sample_index,
  output logic                          empty,
  input  logic                          pop,
  output logic [31:0]                   radius,
  output logic [16:0]                   intensity,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  gbp_pkg::shape_cfg_t shape;
  logic                mq_push;
  logic [31:0]         mq_in_radius;
  logic                mq_full;
  logic                mq_pop;
  logic [31:0]         mq_out_radius;
  logic                mq_empty;

  gbp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .sample_index (sample_index),
    .full         (full),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .shape        (shape),
    .mq_push      (mq_push),
    .mq_radius    (mq_in_radius),
    .mq_full      (mq_full)
  );

  gbp_mid_queue u_mq (
    .clk         (clk),
    .rst         (rst),
    .push        (mq_push),
    .push_radius (mq_in_radius),
    .full        (mq_full),
    .pop         (mq_pop),
    .pop_radius  (mq_out_radius),
    .empty       (mq_empty)
  );

  gbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .shape     (shape),
    .mq_empty  (mq_empty),
    .mq_radius (mq_out_radius),
    .mq_pop    (mq_pop),
    .empty     (empty),
    .pop       (pop),
    .radius    (radius),
    .intensity (intensity)
  );

endmodule

@@ design/gbp_front.sv @@
module gbp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [15:0]                   sample_index,
  output logic                          full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output gbp_pkg::shape_cfg_t           shape,
  output logic                          mq_push,
  output logic [31:0]                   mq_radius,
  input  logic                          mq_full
);

  logic [31:0] min_r;
  logic [31:0] max_r;
  logic [15:0] count_r;
  logic [31:0] bulge_r;
  logic [31:0] step;
  logic        busy;
  logic        loaded;
  logic [4:0]  cnt;
  logic        dv_ok;
  logic [31:0] dv_num;
  logic [15:0] dv_rem;
  logic [31:0] dv_num_next;
  logic [15:0] dv_rem_next;
  logic [16:0] dv_sh;

  logic        va;
  logic        vb;
  logic [47:0] prod;
  logic [31:0] rad_b;
  logic [48:0] sum;
  logic        en_f;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign shape.max_radius   = max_r;
  assign shape.bulge_radius = bulge_r;

  // Step width divider: one quotient bit per cycle.
  always_comb begin
    dv_sh = {dv_rem, dv_num[31]};
    if (dv_sh >= {1'b0, count_r}) begin
      dv_rem_next = 16'(dv_sh - {1'b0, count_r});
      dv_num_next = {dv_num[30:0], 1'b1};
    end else begin
      dv_rem_next = dv_sh[15:0];
      dv_num_next = {dv_num[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_r   <= gbp_pkg::MIN_RESET;
      max_r   <= gbp_pkg::MAX_RESET;
      count_r <= gbp_pkg::COUNT_RESET;
      bulge_r <= gbp_pkg::BULGE_RESET;
      step    <= gbp_pkg::STEP_RESET;
      busy    <= 1'b0;
      loaded  <= 1'b0;
      cnt     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gbp_pkg::REG_MIN_RADIUS:   min_r   <= cfg_data;
        gbp_pkg::REG_MAX_RADIUS:   max_r   <= cfg_data;
        gbp_pkg::REG_SAMPLE_COUNT: count_r <= cfg_data[15:0];
        gbp_pkg::REG_BULGE_RADIUS: bulge_r <= cfg_data;
        default: ;
      endcase
      busy   <= 1'b1;
      loaded <= 1'b0;
    end else if (busy) begin
      if (!loaded) begin
        loaded <= 1'b1;
        cnt    <= '0;
        dv_ok  <= (max_r > min_r) && (count_r != 16'd0);
        dv_num <= max_r - min_r;
        dv_rem <= '0;
      end else begin
        dv_num <= dv_num_next;
        dv_rem <= dv_rem_next;
        cnt    <= cnt + 5'd1;
        if (cnt == 5'(gbp_pkg::STEP_DIV_BITS - 1)) begin
          busy <= 1'b0;
          step <= dv_ok ? dv_num_next : 32'd0;
        end
      end
    end
  end

  assign en_f   = !mq_full;
  assign full   = busy || mq_full;
  assign accept = push && !full;

  assign sum = {17'd0, min_r} + {1'b0, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en_f) begin
      va <= accept;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      prod  <= sample_index * step;
      rad_b <= (sum[48:32] != 17'd0) ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  assign mq_push   = vb && en_f;
  assign mq_radius = rad_b;

endmodule

@@ design/gbp_mid_queue.sv @@
module gbp_mid_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] push_radius,
  output logic        full,
  input  logic        pop,
  output logic [31:0] pop_radius,
  output logic        empty
);

  logic [31:0]                  mem [gbp_pkg::MQ_DEPTH];
  logic [gbp_pkg::MQ_PTR_W-1:0] wptr;
  logic [gbp_pkg::MQ_PTR_W-1:0] rptr;
  logic [gbp_pkg::MQ_CNT_W-1:0] count;
  logic                         do_push;
  logic                         do_pop;

  assign full       = (count == gbp_pkg::MQ_CNT_W'(gbp_pkg::MQ_DEPTH));
  assign empty      = (count == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign pop_radius = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_radius;
  end

endmodule

@@ design/gbp_back.sv @@
module gbp_back (
  input  logic                clk,
  input  logic                rst,
  input  gbp_pkg::shape_cfg_t shape,
  input  logic                mq_empty,
  input  logic [31:0]         mq_radius,
  output logic                mq_pop,
  output logic                empty,
  input  logic                pop,
  output logic [31:0]         radius,
  output logic [16:0]         intensity
);

  localparam int SD1 = gbp_pkg::SQ1_STEPS;
  localparam int SD2 = gbp_pkg::SQ2_STEPS;

  logic                en;
  gbp_pkg::sd_stage_t  e_q;
  gbp_pkg::sd_stage_t  e_n;
  gbp_pkg::sd_stage_t  e_t;
  logic                e_v;
  gbp_pkg::sd_stage_t  sd_q [gbp_pkg::SD_N+1];
  logic                sd_v [gbp_pkg::SD_N+1];
  gbp_pkg::ex_stage_t  ex_q [gbp_pkg::EX_N];
  logic                ex_v [gbp_pkg::EX_N];

  logic [31:0]                  oq_rad [gbp_pkg::OQ_DEPTH];
  logic [16:0]                  oq_int [gbp_pkg::OQ_DEPTH];
  logic [gbp_pkg::OQ_PTR_W-1:0] oq_wptr;
  logic [gbp_pkg::OQ_PTR_W-1:0] oq_rptr;
  logic [gbp_pkg::OQ_CNT_W-1:0] oq_count;
  logic                         oq_wr;
  logic                         oq_rd;
  logic [32:0]                  round_sum;
  logic [16:0]                  int_final;

  // The whole evaluator advances together whenever the output queue has room.
  assign en     = (oq_count != gbp_pkg::OQ_CNT_W'(gbp_pkg::OQ_DEPTH));
  assign mq_pop = en && !mq_empty;

  // Entry: classify bulge or disk and pick the radius whose fourth root is needed.
  always_comb begin
    e_n        = '0;
    e_n.radius = mq_radius;
    e_n.disk   = (mq_radius >= shape.bulge_radius);
    e_n.src    = e_n.disk ? shape.bulge_radius : mq_radius;
    e_n.d3     = 34'(mq_radius - shape.bulge_radius);
  end

  always_comb begin
    e_t    = e_q;
    e_t.d3 = {e_q.d3[32:0], 1'b0} + e_q.d3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v      <= 1'b0;
      sd_v[0]  <= 1'b0;
    end else if (en) begin
      e_v      <= !mq_empty;
      sd_v[0]  <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_q     <= e_n;
      sd_q[0] <= e_t;
    end
  end

  // Square roots and the disk exponent divider run side by side, one bit a stage.
  for (genvar s = 1; s <= gbp_pkg::SD_N; s++) begin : g_sd
    localparam int J = s - 1;
    gbp_pkg::sd_stage_t        prv;
    gbp_pkg::sd_stage_t        nxt;
    logic [gbp_pkg::SQ_REM_W-1:0] sqr_n;
    logic [SD2-1:0]            sqt_n;
    logic [SD1-1:0]            s1_n;
    logic [31:0]               dvr_n;
    logic [gbp_pkg::ED_W-1:0]  dvq_n;
    logic                      sat_n;

    assign prv = sd_q[s-1];

    if (J < SD1) begin : g_sq1
      localparam int I = SD1 - 1 - J;
      always_comb begin
        gbp_pkg::sq_pair_t        st;
        logic [gbp_pkg::SQ1_IN_W-1:0] v1;
        v1 = gbp_pkg::SQ1_IN_W'({prv.src, {(32 - gbp_pkg::FRAC_BITS){1'b0}}});
        if (J == 0) begin
          st = gbp_pkg::sqrt_step('0, '0, v1[2*I+1 -: 2]);
        end else begin
          st = gbp_pkg::sqrt_step(prv.sq_rem, prv.sq_root, v1[2*I+1 -: 2]);
        end
        sqr_n = st.rem;
        sqt_n = st.root;
        s1_n  = prv.s1;
      end
    end else begin : g_sq2
      localparam int M = J - SD1;
      localparam int I = SD2 - 1 - M;
      always_comb begin
        gbp_pkg::sq_pair_t        st;
        logic [gbp_pkg::SQ2_IN_W-1:0] v2;
        logic [SD1-1:0]           s1c;
        s1c = (M == 0) ? prv.sq_root[SD1-1:0] : prv.s1;
        v2  = gbp_pkg::SQ2_IN_W'({s1c, 32'd0});
        if (M == 0) begin
          st = gbp_pkg::sqrt_step('0, '0, v2[2*I+1 -: 2]);
        end else begin
          st = gbp_pkg::sqrt_step(prv.sq_rem, prv.sq_root, v2[2*I+1 -: 2]);
        end
        sqr_n = st.rem;
        sqt_n = st.root;
        s1_n  = s1c;
      end
    end

    if (J < gbp_pkg::ED_W) begin : g_div
      localparam int B = gbp_pkg::ED_W - 1 - J;
      always_comb begin
        logic [31:0]              rin;
        logic [32:0]              sh;
        logic [gbp_pkg::ED_W-1:0] nlow;
        logic                     ge;
        nlow  = {prv.d3[4:0], {gbp_pkg::EXP_FRAC{1'b0}}};
        rin   = (J == 0) ? 32'(prv.d3[33:5]) : prv.dv_rem;
        sh    = {rin, nlow[B]};
        ge    = (sh >= {1'b0, shape.max_radius});
        dvr_n = ge ? 32'(sh - {1'b0, shape.max_radius}) : sh[31:0];
        dvq_n = (J == 0) ? '0 : prv.dv_q;
        dvq_n[B] = ge;
        // A quotient of 32.0 or more is only flagged, never divided out.
        sat_n = (J == 0) ? ({3'b000, prv.d3} >= {shape.max_radius, 5'b00000}) : prv.sat;
      end
    end else begin : g_nodiv
      assign dvr_n = prv.dv_rem;
      assign dvq_n = prv.dv_q;
      assign sat_n = prv.sat;
    end

    always_comb begin
      nxt         = prv;
      nxt.sq_rem  = sqr_n;
      nxt.sq_root = sqt_n;
      nxt.s1      = s1_n;
      nxt.dv_rem  = dvr_n;
      nxt.dv_q    = dvq_n;
      nxt.sat     = sat_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd_v[s] <= 1'b0;
      end else if (en) begin
        sd_v[s] <= sd_v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) sd_q[s] <= nxt;
    end
  end

  // Bulge exponent 0.02 * r^0.25, rounded, plus the disk term; then exp(-x) of that sum.
  for (genvar s = 0; s < gbp_pkg::EX_N; s++) begin : g_ex
    gbp_pkg::ex_stage_t nxt;

    if (s == 0) begin : g_eb
      always_comb begin
        logic [SD2+26:0] mp;
        logic [SD2+27:0] mr;
        gbp_pkg::sd_stage_t src;
        src        = sd_q[gbp_pkg::SD_N];
        mp         = src.sq_root * gbp_pkg::K_Q32;
        mr         = {1'b0, mp} + (SD2 + 28)'(33'h0_8000_0000);
        nxt        = '0;
        nxt.radius = src.radius;
        nxt.big    = src.disk && src.sat;
        nxt.x      = gbp_pkg::X_W'(mr[SD2+27:32]);
        nxt.ed     = src.disk ? src.dv_q : '0;
      end
    end else if (s == 1) begin : g_sum
      always_comb begin
        logic [gbp_pkg::X_W-1:0] x;
        x        = ex_q[0].x + gbp_pkg::X_W'(ex_q[0].ed);
        nxt      = ex_q[0];
        nxt.x    = x;
        nxt.zero = (x == '0);
        nxt.big  = ex_q[0].big || x[gbp_pkg::X_W-1];
        nxt.f    = {x[gbp_pkg::X_W-2:0], 3'b000};
        nxt.r    = gbp_pkg::ONE_Q32;
      end
    end else if (s < 2 + gbp_pkg::HORNER_N) begin : g_horner
      localparam int T = s - 2;
      localparam int K = gbp_pkg::HORNER_TERMS - T / 3;
      localparam int H = T % 3;
      if (H == 0) begin : g_mul
        always_comb begin
          logic [64:0] pr;
          pr    = ex_q[s-1].f * ex_q[s-1].r;
          nxt   = ex_q[s-1];
          nxt.p = pr[63:32];
        end
      end else if (H == 1) begin : g_rcp
        always_comb begin
          logic [64:0] pr;
          pr     = ex_q[s-1].p * gbp_pkg::recip(K);
          nxt    = ex_q[s-1];
          nxt.qa = pr[63:32];
        end
      end else begin : g_fix
        always_comb begin
          logic [31:0] rem;
          logic [31:0] d;
          // The reciprocal estimate is at most one short of the true quotient.
          rem   = ex_q[s-1].p - 32'(ex_q[s-1].qa * 32'(K));
          d     = (rem >= 32'(K)) ? ex_q[s-1].qa + 32'd1 : ex_q[s-1].qa;
          nxt   = ex_q[s-1];
          nxt.r = gbp_pkg::ONE_Q32 - {1'b0, d};
        end
      end
    end else begin : g_sq
      always_comb begin
        logic [31:0] rc;
        logic [63:0] pr;
        rc    = ex_q[s-1].r[32] ? 32'hFFFF_FFFF : ex_q[s-1].r[31:0];
        pr    = rc * rc;
        nxt   = ex_q[s-1];
        nxt.r = {1'b0, pr[63:32]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ex_v[s] <= 1'b0;
      end else if (en) begin
        ex_v[s] <= (s == 0) ? sd_v[gbp_pkg::SD_N] : ex_v[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) ex_q[s] <= nxt;
    end
  end

  // Output queue.
  assign round_sum = {1'b0, ex_q[gbp_pkg::EX_N-1].r[31:0]} + 33'd32768;
  always_comb begin
    if (ex_q[gbp_pkg::EX_N-1].big) begin
      int_final = 17'd0;
    end else if (ex_q[gbp_pkg::EX_N-1].zero) begin
      int_final = gbp_pkg::INT_ONE;
    end else begin
      int_final = round_sum[32:16];
    end
  end

  assign oq_wr     = en && ex_v[gbp_pkg::EX_N-1];
  assign empty     = (oq_count == '0);
  assign oq_rd     = pop && !empty;
  assign radius    = oq_rad[oq_rptr];
  assign intensity = oq_int[oq_rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      if (oq_wr) oq_wptr <= oq_wptr + 1'b1;
      if (oq_rd) oq_rptr <= oq_rptr + 1'b1;
      if (oq_wr && !oq_rd) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_rd && !oq_wr) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_rad[oq_wptr] <= ex_q[gbp_pkg::EX_N-1].radius;
      oq_int[oq_wptr] <= int_final;
    end
  end

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    oq_wr |-> (oq_count != gbp_pkg::OQ_CNT_W'(gbp_pkg::OQ_DEPTH)))
    else $error("output queue written while full");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ex_v[gbp_pkg::EX_N-1]) && $stable(sd_v[gbp_pkg::SD_N]))
    else $error("evaluator moved while stalled");

  a_intensity_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (intensity <= gbp_pkg::INT_ONE))
    else $error("intensity above 1.0");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    mq_pop |-> !mq_empty)
    else $error("evaluator took from an empty queue");

endmodule

@@ tb/testbench.sv @@
module testbench;

  localparam logic [gbp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'hC5;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int STALL_CYCLES = 400;
  localparam int IDLE_PCT = 21;

  typedef struct packed {
    logic [31:0] radius;
    logic [16:0] intensity;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [15:0] sample_index = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic full, empty, cfg_ready;
  logic [31:0] radius;
  logic [16:0] intensity;

  galaxy_brightness_profile dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample_index(sample_index),
    .empty(empty), .pop(pop), .radius(radius), .intensity(intensity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block's registers, updated on each accepted write.
  logic [31:0] min_r = gbp_pkg::MIN_RESET;
  logic [31:0] max_r = gbp_pkg::MAX_RESET;
  logic [15:0] n_samples = gbp_pkg::COUNT_RESET;
  logic [31:0] bulge_r = gbp_pkg::BULGE_RESET;

  logic [15:0] index_queue[$];
  curve_point_t point_queue[$];
  int errors = 0;
  int points_checked = 0;
  int writes_done = 0;
  bit item_taken = 1'b0;
  bit no_idle = 1'b0;
  bit stall_req = 1'b0;
  bit stall_done = 1'b0;
  int stall_cnt = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // exp(-x) for a Q.24 exponent, answer in Q1.16.
  function automatic logic [16:0] exp_decay(input logic [63:0] x);
    logic [63:0] f, r;
    if (x == 0) return gbp_pkg::INT_ONE;
    if (x >= (64'd32 << 24)) return 17'd0;
    f = x << 3;
    r = 64'd1 << 32;
    for (int k = 12; k >= 1; k--) r = (64'd1 << 32) - (((f * r) >> 32) / 64'(k));
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    for (int i = 0; i < 5; i++) r = (r * r) >> 32;
    return 17'((r + 64'd32768) >> 16);
  endfunction

  function automatic logic [63:0] bulge_law_exponent(input logic [31:0] rad);
    logic [63:0] s, q;
    s = isqrt(64'(rad) << (32 - gbp_pkg::FRAC_BITS));
    q = isqrt(s << 32);
    return (q * 64'(gbp_pkg::K_Q32) + (64'd1 << 31)) >> 32;
  endfunction

  function automatic curve_point_t sample_point(input logic [15:0] idx);
    logic [63:0] step, rad, ed;
    curve_point_t p;
    step = 0;
    if (max_r > min_r && n_samples != 0) step = 64'(max_r - min_r) / 64'(n_samples);
    rad = 64'(min_r) + 64'(idx) * step;
    if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
    p.radius = rad[31:0];
    if (p.radius < bulge_r) begin
      p.intensity = exp_decay(bulge_law_exponent(p.radius));
    end else if (max_r == 0) begin
      p.intensity = 0;
    end else begin
      ed = ((64'd3 * 64'(p.radius - bulge_r)) << 24) / 64'(max_r);
      p.intensity = (ed >= (64'd32 << 24)) ? 17'd0 :
                    exp_decay(bulge_law_exponent(bulge_r) + ed);
    end
    return p;
  endfunction

  // Sender: holds an item until it is taken, otherwise idles now and then.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && !item_taken)) begin
      if (index_queue.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        sample_index <= index_queue.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_cnt > 0) begin
      pop <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if (stall_req && !stall_done) begin
      pop <= 1'b0;
      stall_cnt <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      pop <= no_idle || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    curve_point_t want;
    item_taken = push && !full;
    if (!rst) begin
      if (item_taken) point_queue.push_back(sample_point(sample_index));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gbp_pkg::REG_MIN_RADIUS:   min_r = cfg_data;
          gbp_pkg::REG_MAX_RADIUS:   max_r = cfg_data;
          gbp_pkg::REG_SAMPLE_COUNT: n_samples = cfg_data[15:0];
          gbp_pkg::REG_BULGE_RADIUS: bulge_r = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (point_queue.size() == 0) begin
          $display("%0t: result with nothing expected: radius %h intensity %h",
                   $time, radius, intensity);
          errors++;
        end else begin
          want = point_queue.pop_front();
          points_checked++;
          if (radius !== want.radius) begin
            $display("%0t: radius expected %h actual %h", $time, want.radius, radius);
            errors++;
          end
          if (intensity !== want.intensity) begin
            $display("%0t: intensity expected %h actual %h (radius %h)",
                     $time, want.intensity, intensity, want.radius);
            errors++;
          end
        end
      end
      if (item_taken || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [gbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    writes_done++;
  endtask

  task automatic set_profile(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [15:0] cnt, input logic [31:0] blg);
    write_reg(gbp_pkg::REG_MIN_RADIUS, lo);
    write_reg(gbp_pkg::REG_MAX_RADIUS, hi);
    write_reg(gbp_pkg::REG_SAMPLE_COUNT, {16'h0, cnt});
    write_reg(gbp_pkg::REG_BULGE_RADIUS, blg);
  endtask

  task automatic drain();
    do @(posedge clk); while (index_queue.size() > 0 || push || point_queue.size() > 0);
  endtask

  task automatic random_items(input int n);
    for (int i = 0; i < n; i++) begin
      if (n_samples != 0 && $urandom_range(9) < 8)
        index_queue.push_back(16'($urandom_range(n_samples - 1)));
      else
        index_queue.push_back(16'($urandom));
    end
  endtask

  initial begin
    logic [31:0] lo, hi, blg;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: around the bulge edge, the last sample and far extrapolation.
    index_queue = '{16'd0, 16'd1, 16'd10, 16'd25, 16'd26, 16'd100,
                    16'd255, 16'd256, 16'd1000, 16'hFFFF, 16'hAAAA, 16'h5555};
    drain();

    // Zero-width range and zero maximum: radius zero sits on the bulge edge.
    set_profile(32'd0, 32'd0, 16'd1, 32'd0);
    index_queue = '{16'd0, 16'hFFFF};
    drain();
    write_reg(gbp_pkg::REG_BULGE_RADIUS, 32'd1);
    index_queue = '{16'd0, 16'd7};
    drain();

    // Everything at the top of the range; reversed range below it.
    set_profile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    index_queue = '{16'd0, 16'hFFFF};
    drain();
    set_profile(32'h8000_0000, 32'h0000_1000, 16'd4, 32'h0001_0000);
    index_queue = '{16'd3, 16'd9};
    drain();

    // Huge step: radius saturates; zero sample count gives a zero step.
    set_profile(32'd0, 32'hFFFF_FFFF, 16'd1, 32'h0100_0000);
    index_queue = '{16'd0, 16'd1, 16'd2, 16'hFFFF};
    drain();
    write_reg(gbp_pkg::REG_SAMPLE_COUNT, 32'd0);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    index_queue = '{16'd0, 16'd12345};
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      lo = $urandom >> $urandom_range(31, 8);
      hi = lo + ($urandom >> $urandom_range(31, 4));
      blg = (ph == 5) ? 32'hFFFF_FFFF : ($urandom >> $urandom_range(31, 6));
      set_profile(lo, (hi == 0) ? 32'd1 : hi,
                  (ph == 3) ? 16'hFFFF : 16'($urandom_range(1, 512)), blg);
      if (ph == 2) stall_req = 1'b1;
      no_idle = (ph == 4);
      random_items(120);
      drain();
    end
    no_idle = 1'b0;

    repeat (120) @(posedge clk);
    $display("Checked %0d curve points over %0d register writes,", points_checked,
             writes_done);
    $display("covering range extremes, saturation, bulge/disk crossover and a backed-up output.");
    if (errors == 0 && point_queue.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0t: %0d mismatches, %0d points never seen", $time, errors,
               point_queue.size());
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
